>>> hw/rtl/lrukc_pkg.sv
// Shared types and constants for the LRU keyed cache table.
package lrukc_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CAP_BITS     = 7;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PROBE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_REFUSED = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

    typedef struct packed {
        t_op                     opcode;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [PAYLOAD_BITS-1:0] data_out;
    } t_resp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_UPDATE,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MD_TOUCH,
        MD_REMOVE,
        MD_INSERT
    } t_mode;

endpackage

>>> hw/rtl/lru_keyed_cache_table.sv
// Fully associative key-to-payload table with least-recently-used replacement.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ----------------------------
//  in        in         i_in_valid / o_in_ready      i_in  (opcode, key, payload)
//  out       out        o_out_valid / i_out_ready    o_out (status, data_out)
//  cfg       in         i_cfg_we                     i_cfg_data (capacity)
//
//  After reset the tag store is swept clear one entry at a time; no request is
//  taken meanwhile, capacity writes are taken as ever.
//  A request that changes nothing (miss, probe, refused or present insert)
//  takes the search scan alone; one that updates the table (lookup hit, remove
//  hit, insert) takes a rank update pass after it as well. One tag store read
//  port and one write port carry both passes, one entry each cycle.
//  The result sits in an output register; a stalled result holds it, and the
//  next request is taken while it waits, blocking only at its own finish.
module lru_keyed_cache_table #(
    parameter int ENTRIES = lrukc_pkg::ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrukc_pkg::CAP_BITS-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lrukc_pkg::t_req                  i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lrukc_pkg::t_resp                 o_out
);

    localparam int KB   = lrukc_pkg::KEY_BITS;
    localparam int PB   = lrukc_pkg::PAYLOAD_BITS;
    localparam int IW   = $clog2(ENTRIES);
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int CW   = ((CNTW > lrukc_pkg::CAP_BITS) ? CNTW : lrukc_pkg::CAP_BITS) + 1;
    localparam int WW   = 1 + IW + KB;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Tag store word: valid, recency rank, key.
    logic [WW-1:0] tag_mem [ENTRIES];
    logic [PB-1:0] pay_mem [ENTRIES];
    logic [WW-1:0] rd_q;
    logic [PB-1:0] pay_q;

    logic          m_we;
    logic [IW-1:0] m_wa;
    logic [WW-1:0] m_wd;
    logic          pw_en;
    logic [IW-1:0] pw_addr;

    lrukc_pkg::t_state r_state, n_state;
    lrukc_pkg::t_mode  r_mode, n_mode;
    lrukc_pkg::t_req   r_req, n_req;
    lrukc_pkg::t_status r_status, n_status;
    lrukc_pkg::t_resp  r_out, n_out;
    logic                           r_out_valid, n_out_valid;
    logic [lrukc_pkg::CAP_BITS-1:0] r_cap, n_cap;
    logic [CNTW-1:0] r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_iss, n_iss;
    logic            r_dval, n_dval;
    logic [IW-1:0]   r_didx, n_didx;
    logic            r_hit, n_hit;
    logic [IW-1:0]   r_hit_idx, n_hit_idx;
    logic [IW-1:0]   r_hit_rank, n_hit_rank;
    logic            r_free_ok, n_free_ok;
    logic [IW-1:0]   r_free_idx, n_free_idx;
    logic            r_old_ok, n_old_ok;
    logic [IW-1:0]   r_old_idx, n_old_idx;
    logic            r_evict, n_evict;
    logic [IW-1:0]   r_slot, n_slot;

    logic          e_valid;
    logic [IW-1:0] e_rank;
    logic [KB-1:0] e_key;
    logic [CW-1:0] eff_cap;
    logic          overflow;
    logic          do_evict;
    logic [IW-1:0] ins_slot;
    logic          ins_ok;

    assign e_valid = rd_q[WW-1];
    assign e_rank  = rd_q[KB+IW-1:KB];
    assign e_key   = rd_q[KB-1:0];

    // Capacity above the table depth saturates at the depth.
    assign eff_cap  = (CW'(r_cap) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cap);
    assign overflow = (CW'(r_count) + CW'(1)) > eff_cap;

    // Evicting the oldest entry frees its slot; the new entry takes the lowest
    // free index, which is either the first empty slot seen or the victim.
    assign do_evict = overflow && r_old_ok;
    assign ins_ok   = do_evict || r_free_ok;
    always_comb begin
        if (do_evict && !(r_free_ok && (r_free_idx < r_old_idx))) begin
            ins_slot = r_old_idx;
        end else begin
            ins_slot = r_free_idx;
        end
    end

    assign o_in_ready  = (r_state == lrukc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Tag and payload stores.
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            tag_mem[m_wa] <= m_wd;
        end
        rd_q <= tag_mem[r_idx];
        if (pw_en) begin
            pay_mem[pw_addr] <= r_req.payload;
        end
        pay_q <= pay_mem[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrukc_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
            r_cap       <= lrukc_pkg::CAP_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_iss       <= 1'b0;
            r_dval      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_iss       <= n_iss;
            r_dval      <= n_dval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_req      <= n_req;
        r_status   <= n_status;
        r_out      <= n_out;
        r_didx     <= n_didx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_old_ok   <= n_old_ok;
        r_old_idx  <= n_old_idx;
        r_evict    <= n_evict;
        r_slot     <= n_slot;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_req       = r_req;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cap       = r_cap;
        n_count     = r_count;
        n_idx       = r_idx;
        n_iss       = r_iss;
        n_dval      = 1'b0;
        n_didx      = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_rank  = r_hit_rank;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_old_ok    = r_old_ok;
        n_old_idx   = r_old_idx;
        n_evict     = r_evict;
        n_slot      = r_slot;
        m_we        = 1'b0;
        m_wa        = r_didx;
        m_wd        = rd_q;
        pw_en       = 1'b0;
        pw_addr     = ins_slot;

        if (i_cfg_we) begin
            n_cap = i_cfg_data;
        end
        // Drop the held result once taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Scan pipeline shared by search and update: issue one read a cycle,
        // the data comes back in the following cycle tagged with its index.
        if ((r_state == lrukc_pkg::S_SEARCH) || (r_state == lrukc_pkg::S_UPDATE)) begin
            n_dval = r_iss;
            if (r_iss) begin
                if (r_idx == LAST) begin
                    n_iss = 1'b0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
        end

        unique case (r_state)
            lrukc_pkg::S_CLEAR: begin
                m_we = 1'b1;
                m_wa = r_idx;
                m_wd = '0;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = lrukc_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            lrukc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_old_ok  = 1'b0;
                    n_idx     = '0;
                    n_iss     = 1'b1;
                    n_state   = lrukc_pkg::S_SEARCH;
                end
            end

            lrukc_pkg::S_SEARCH: begin
                if (r_dval) begin
                    if (e_valid && (e_key == r_req.key) && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_didx;
                        n_hit_rank = e_rank;
                    end
                    if (!e_valid && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_didx;
                    end
                    // Ranks run 0..count-1, so the oldest holds count-1.
                    if (e_valid && (CNTW'(e_rank) == (r_count - CNTW'(1)))) begin
                        n_old_ok  = 1'b1;
                        n_old_idx = r_didx;
                    end
                    if (r_didx == LAST) begin
                        n_state = lrukc_pkg::S_DECIDE;
                    end
                end
            end

            lrukc_pkg::S_DECIDE: begin
                n_idx   = '0;
                n_iss   = 1'b1;
                n_state = lrukc_pkg::S_FINISH;
                unique case (r_req.opcode)
                    lrukc_pkg::OP_LOOKUP: begin
                        n_status = r_hit ? lrukc_pkg::ST_OK : lrukc_pkg::ST_MISS;
                        if (r_hit) begin
                            n_mode  = lrukc_pkg::MD_TOUCH;
                            n_state = lrukc_pkg::S_UPDATE;
                        end
                    end
                    lrukc_pkg::OP_INSERT: begin
                        priority if (r_cap == '0) begin
                            n_status = lrukc_pkg::ST_REFUSED;
                        end else if (r_hit) begin
                            n_status = lrukc_pkg::ST_PRESENT;
                        end else begin
                            n_status = lrukc_pkg::ST_OK;
                            if (ins_ok) begin
                                n_mode  = lrukc_pkg::MD_INSERT;
                                n_evict = do_evict;
                                n_slot  = ins_slot;
                                pw_en   = 1'b1;
                                // Eviction and fill cancel in the count.
                                if (!do_evict) begin
                                    n_count = r_count + CNTW'(1);
                                end
                                n_state = lrukc_pkg::S_UPDATE;
                            end
                        end
                    end
                    lrukc_pkg::OP_REMOVE: begin
                        n_status = r_hit ? lrukc_pkg::ST_OK : lrukc_pkg::ST_MISS;
                        if (r_hit) begin
                            n_mode  = lrukc_pkg::MD_REMOVE;
                            n_count = r_count - CNTW'(1);
                            n_state = lrukc_pkg::S_UPDATE;
                        end
                    end
                    lrukc_pkg::OP_PROBE: begin
                        n_status = r_hit ? lrukc_pkg::ST_OK : lrukc_pkg::ST_MISS;
                    end
                    default: begin
                        n_status = lrukc_pkg::ST_MISS;
                    end
                endcase
            end

            lrukc_pkg::S_UPDATE: begin
                if (r_dval) begin
                    m_we = 1'b1;
                    m_wa = r_didx;
                    m_wd = rd_q;
                    unique case (r_mode)
                        lrukc_pkg::MD_TOUCH: begin
                            if (r_didx == r_hit_idx) begin
                                m_wd[KB+IW-1:KB] = '0;
                            end else if (e_valid && (e_rank < r_hit_rank)) begin
                                m_wd[KB+IW-1:KB] = e_rank + IW'(1);
                            end
                        end
                        lrukc_pkg::MD_REMOVE: begin
                            if (r_didx == r_hit_idx) begin
                                m_wd[WW-1] = 1'b0;
                            end else if (e_valid && (e_rank > r_hit_rank)) begin
                                m_wd[KB+IW-1:KB] = e_rank - IW'(1);
                            end
                        end
                        lrukc_pkg::MD_INSERT: begin
                            priority if (r_didx == r_slot) begin
                                m_wd = {1'b1, {IW{1'b0}}, r_req.key};
                            end else if (r_evict && (r_didx == r_old_idx)) begin
                                m_wd[WW-1] = 1'b0;
                            end else if (e_valid) begin
                                m_wd[KB+IW-1:KB] = e_rank + IW'(1);
                            end
                        end
                        default: begin
                            m_we = 1'b0;
                        end
                    endcase
                    if (r_didx == LAST) begin
                        n_state = lrukc_pkg::S_FINISH;
                    end
                end
            end

            lrukc_pkg::S_FINISH: begin
                n_iss = 1'b0;
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.status   = r_status;
                    n_out.data_out = ((r_req.opcode == lrukc_pkg::OP_LOOKUP) && r_hit)
                                     ? pay_q : '0;
                    n_out_valid    = 1'b1;
                    n_state        = lrukc_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lrukc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(ENTRIES))
        else $error("entry count exceeds table depth");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == lrukc_pkg::S_FINISH))
        else $error("result raised outside finish");

    a_count_only_on_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lrukc_pkg::S_DECIDE) |=> $stable(r_count))
        else $error("entry count moved outside decide");

    a_no_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lrukc_pkg::S_IDLE) || (r_state == lrukc_pkg::S_SEARCH)) |-> !m_we)
        else $error("tag store written during search or idle");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU keyed cache table, with an in-bench LRU predictor.
module testbench;
    import lrukc_pkg::*;

    localparam int NUM_SLOTS  = ENTRIES_DEF;
    localparam int POOL_MAX   = 96;
    localparam int SETTLE_CYC = 2 * NUM_SLOTS + 10;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_req                i_in        = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_resp               o_out;

    // Bench-side copy of the table: one slot per entry, rank 0 is most recent.
    logic                    slot_used [NUM_SLOTS];
    logic [KEY_BITS-1:0]     slot_key  [NUM_SLOTS];
    logic [PAYLOAD_BITS-1:0] slot_data [NUM_SLOTS];
    int unsigned             slot_rank [NUM_SLOTS];
    int unsigned             used_count;
    logic [CAP_BITS-1:0]     cap_setting;

    t_resp               pending_replies[$];
    logic [KEY_BITS-1:0] key_pool[POOL_MAX];
    int                  mismatch_count = 0;
    bit                  steady_flow    = 1'b0;

    lru_keyed_cache_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Evict slot idx from the bench table; entries older than it move up one rank.
    function automatic void retire_slot(int idx);
        int unsigned r;
        r = slot_rank[idx];
        slot_used[idx] = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i] && slot_rank[i] > r)
                slot_rank[i]--;
        if (used_count > 0)
            used_count--;
    endfunction

    // Apply one request to the bench table and return the reply it must produce.
    function automatic t_resp predict_access(t_req r);
        t_resp       res;
        int          hit;
        int          victim;
        int          free_slot;
        int unsigned eff_cap;
        int unsigned r_hit;
        res.status   = ST_OK;
        res.data_out = '0;
        // Capacity above the table size saturates at the table size.
        eff_cap = (cap_setting > NUM_SLOTS) ? NUM_SLOTS : cap_setting;
        hit = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (hit < 0 && slot_used[i] && slot_key[i] == r.key)
                hit = i;
        case (r.opcode)
            OP_LOOKUP: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    // Promote the hit entry; everything newer ages by one.
                    res.data_out = slot_data[hit];
                    r_hit = slot_rank[hit];
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (slot_used[i] && slot_rank[i] < r_hit)
                            slot_rank[i]++;
                    slot_rank[hit] = 0;
                end
            end
            OP_INSERT: begin
                // Zero capacity refuses before the presence test.
                if (eff_cap == 0) begin
                    res.status = ST_REFUSED;
                end else if (hit >= 0) begin
                    res.status = ST_PRESENT;
                end else begin
                    // Evict at most one entry, even if the count sits above capacity.
                    if (used_count + 1 > eff_cap) begin
                        victim = -1;
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (slot_used[i] &&
                                (victim < 0 || slot_rank[i] > slot_rank[victim]))
                                victim = i;
                        if (victim >= 0)
                            retire_slot(victim);
                    end
                    free_slot = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (free_slot < 0 && !slot_used[i])
                            free_slot = i;
                    if (free_slot >= 0) begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (slot_used[i])
                                slot_rank[i]++;
                        slot_used[free_slot] = 1'b1;
                        slot_key[free_slot]  = r.key;
                        slot_data[free_slot] = r.payload;
                        slot_rank[free_slot] = 0;
                        used_count++;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit < 0)
                    res.status = ST_MISS;
                else
                    retire_slot(hit);
            end
            default: begin
                if (hit < 0)
                    res.status = ST_MISS;
            end
        endcase
        return res;
    endfunction

    // Present one request, hold it until accepted, then log its expected reply.
    task automatic send_request(t_op op, logic [KEY_BITS-1:0] key,
                                logic [PAYLOAD_BITS-1:0] payload);
        t_req r;
        r.opcode  = op;
        r.key     = key;
        r.payload = payload;
        if (!steady_flow && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 30);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_replies.push_back(predict_access(r));
    endtask

    // Drop valid and hold until every outstanding reply has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= value;
        cap_setting  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random requests over a small key pool so hits, duplicates and evictions
    // are common; a tenth of the keys are fully random and mostly miss.
    task automatic run_random_traffic(int n_req, int pool_size, int insert_pct);
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int n = 0; n < n_req; n++) begin
            if ($urandom_range(0, 99) < insert_pct)
                op = OP_INSERT;
            else
                op = t_op'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 90)
                key = key_pool[$urandom_range(0, pool_size - 1)];
            else
                key = $urandom;
            send_request(op, key, $urandom);
        end
    endtask

    // Lookup and probe on an empty table at both key extremes, then a remove of a random key.
    task automatic test_empty_table();
        send_request(OP_LOOKUP, '0, '1);
        send_request(OP_PROBE, '1, '0);
        send_request(OP_REMOVE, $urandom, $urandom);
    endtask

    // Hits return the stored payload; a duplicate insert keeps the old one.
    task automatic test_hits_and_duplicates();
        send_request(OP_INSERT, '0, '1);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_LOOKUP, '0, '0);
        send_request(OP_LOOKUP, '1, '1);
        send_request(OP_PROBE, '0, $urandom);
        send_request(OP_INSERT, '0, $urandom);
        send_request(OP_LOOKUP, '0, $urandom);
        send_request(OP_REMOVE, '1, $urandom);
        send_request(OP_LOOKUP, '1, $urandom);
    endtask

    // Zero capacity refuses every insert, present key included; reads still work.
    task automatic test_zero_capacity();
        wait_idle();
        write_capacity('0);
        send_request(OP_INSERT, 32'h1234_5678, $urandom);
        send_request(OP_INSERT, '0, $urandom);
        send_request(OP_LOOKUP, '0, $urandom);
    endtask

    // Capacity two: a lookup refreshes the older entry, so the newer one is evicted.
    task automatic test_lru_eviction();
        wait_idle();
        write_capacity(7'd2);
        send_request(OP_INSERT, 32'hA5A5_0001, 32'h1111_1111);
        send_request(OP_LOOKUP, '0, $urandom);
        send_request(OP_INSERT, 32'h5A5A_0002, 32'h2222_2222);
        send_request(OP_PROBE, 32'hA5A5_0001, $urandom);
        send_request(OP_LOOKUP, '0, $urandom);
        send_request(OP_PROBE, 32'h5A5A_0002, $urandom);
    endtask

    // All-ones capacity behaves as a full table; enough inserts to wrap it.
    task automatic test_saturated_capacity();
        wait_idle();
        write_capacity('1);
        run_random_traffic(250, 96, 45);
    endtask

    task automatic test_full_capacity();
        wait_idle();
        write_capacity(7'd64);
        run_random_traffic(200, 80, 35);
    endtask

    // Capacity dropped below the live count: inserts evict one and the count holds.
    task automatic test_capacity_below_count();
        wait_idle();
        write_capacity(7'd5);
        run_random_traffic(150, 20, 40);
    endtask

    task automatic test_tiny_capacity();
        wait_idle();
        write_capacity(7'd1);
        run_random_traffic(100, 8, 40);
        wait_idle();
        write_capacity(7'd2);
        run_random_traffic(100, 8, 40);
    endtask

    task automatic test_zero_capacity_traffic();
        wait_idle();
        write_capacity('0);
        run_random_traffic(60, 16, 50);
    endtask

    // Capacity above the table size, run back to back with no idling on either side.
    task automatic test_steady_stream();
        wait_idle();
        write_capacity(7'd100);
        steady_flow = 1'b1;
        run_random_traffic(90, 72, 40);
        steady_flow = 1'b0;
    endtask

    // Receiver: stall at random, except during the steady stretch.
    always @(posedge i_clk)
        i_out_ready <= steady_flow || ($urandom_range(0, 99) >= 8);

    // Compare each delivered reply against the oldest expectation.
    always @(posedge i_clk) begin : check_replies
        t_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: status %0d data_out %h",
                       o_out.status, o_out.data_out);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out.status);
                    mismatch_count++;
                end
                if (o_out.data_out !== want.data_out) begin
                    $error("data_out: expected %h, actual %h",
                           want.data_out, o_out.data_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_rank[i] = 0;
        end
        used_count  = 0;
        cap_setting = CAP_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_hits_and_duplicates();
        test_zero_capacity();
        test_lru_eviction();
        test_saturated_capacity();
        test_full_capacity();
        test_capacity_below_count();
        test_tiny_capacity();
        test_zero_capacity_traffic();
        test_steady_stream();

        // Drain, then watch long enough to catch any stray reply.
        wait_idle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #8_000_000;
        $error("run timed out with %0d replies outstanding", pending_replies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lrukc_pkg.sv
hw/rtl/lru_keyed_cache_table.sv
tb/testbench.sv
